// ----- sv/usvg_pkg.sv -----
// shared types, constants and helpers of the uv sphere vertex generator
`default_nettype none
package usvg_pkg;

	localparam int IDX_W = 11;
	localparam int TEX_W = 28;
	localparam int SC_LAT = 18;
	localparam logic [IDX_W-1:0] MAX_DIVISIONS = 11'd1024;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [31:0] TWO_PI_Q29 = 32'hC90F_DAA2;

	typedef enum logic [2:0] {
		REG_RADIUS,
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_CENTER_Z,
		REG_SECTORS,
		REG_STACKS,
		REG_INVERT
	} cfg_reg_t;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

	typedef struct packed {
		logic [16:0] tex_s;
		logic [16:0] tex_t;
		logic        err;
	} side_t;

	// fraction bits kept by the index dividers
	function automatic int quo_shift(input int ab);
		return (ab + 1 > 17) ? ab + 1 : 17;
	endfunction

	function automatic int pipe_latency(input int ab);
		return IDX_W + quo_shift(ab) + SC_LAT + 5;
	endfunction

	function automatic int sin_k(input int n);
		case (n)
			0: return 72;
			1: return 42;
			2: return 20;
			3: return 6;
			default: return 2;
		endcase
	endfunction

	function automatic int cos_k(input int n);
		case (n)
			0: return 90;
			1: return 56;
			2: return 30;
			3: return 12;
			default: return 2;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] eff_count(input logic [IDX_W-1:0] n);
		if (n == '0) begin
			return 11'd1;
		end
		if (n > MAX_DIVISIONS) begin
			return MAX_DIVISIONS;
		end
		return n;
	endfunction

	// round half up one bit, then clamp at one
	function automatic logic [16:0] tex_round(input logic [TEX_W-1:0] x);
		logic [TEX_W:0] s;
		s = {1'b0, x} + {{TEX_W{1'b0}}, 1'b1};
		if (s[TEX_W:1] > 28'd65536) begin
			return 17'd65536;
		end
		return s[17:1];
	endfunction

endpackage
`default_nettype wire

// ----- sv/usvg_div_cell.sv -----
// one quotient bit of the pipelined index divider
`default_nettype none
module usvg_div_cell #(
	parameter int STEP = 0,
	parameter int QW = 28
) (
	input  wire logic                        clk,
	input  wire logic [usvg_pkg::IDX_W-1:0]  d_i,
	input  wire logic [usvg_pkg::IDX_W-1:0]  idx_i,
	input  wire logic [usvg_pkg::IDX_W-1:0]  rem_i,
	input  wire logic [QW-1:0]               quot_i,
	output logic      [usvg_pkg::IDX_W-1:0]  idx_o,
	output logic      [usvg_pkg::IDX_W-1:0]  rem_o,
	output logic      [QW-1:0]               quot_o
);
	import usvg_pkg::*;

	logic          nbit;
	logic [IDX_W:0] rem_sh;
	logic          ge;

	// numerator is the index followed by zeros
	if (STEP < IDX_W) begin : g_num
		assign nbit = idx_i[IDX_W-1-STEP];
	end else begin : g_zero
		assign nbit = 1'b0;
	end

	assign rem_sh = {rem_i, nbit};
	assign ge     = rem_sh >= {1'b0, d_i};

	always_ff @(posedge clk) begin
		idx_o  <= idx_i;
		rem_o  <= ge ? IDX_W'(rem_sh - {1'b0, d_i}) : rem_sh[IDX_W-1:0];
		quot_o <= {quot_i[QW-2:0], ge};
	end

endmodule
`default_nettype wire

// ----- sv/usvg_horner_cell.sv -----
// one horner step of the octant sine/cosine series
`default_nettype none
module usvg_horner_cell #(
	parameter int K = 2,
	parameter bit FINAL = 1'b0
) (
	input  wire logic        clk,
	input  wire logic [29:0] r_i,
	input  wire logic [29:0] r2_i,
	input  wire logic [30:0] a_i,
	output logic      [29:0] r_o,
	output logic      [29:0] r2_o,
	output logic      [30:0] a_o
);
	import usvg_pkg::*;

	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);

	logic [60:0] p_s1;
	logic [29:0] r_s1, r2_s1, r_s2, r2_s2;
	logic [30:0] t, t_s2;
	logic [62:0] qm_s2;
	logic [30:0] q0, rem, q;

	assign t   = p_s1[60:30];
	assign q0  = qm_s2[62:32];
	// reciprocal estimate is low by at most one
	assign rem = t_s2 - q0 * 31'(K);
	assign q   = q0 + {30'b0, rem >= 31'(K)};

	always_ff @(posedge clk) begin
		p_s1  <= 61'(FINAL ? r_i : r2_i) * 61'(a_i);
		r_s1  <= r_i;
		r2_s1 <= r2_i;
		qm_s2 <= 63'(t) * 63'(RECIP);
		t_s2  <= t;
		r_s2  <= r_s1;
		r2_s2 <= r2_s1;
		a_o   <= FINAL ? t_s2 : Q30_ONE - q;
		r_o   <= r_s2;
		r2_o  <= r2_s2;
	end

endmodule
`default_nettype wire

// ----- sv/usvg_sincos.sv -----
// pipelined sine and cosine of a phase given in turns
`default_nettype none
module usvg_sincos #(
	parameter int ANGLE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic [ANGLE_BITS-1:0] phase_i,
	output logic signed [31:0]         sin_o,
	output logic signed [31:0]         cos_o
);
	import usvg_pkg::*;

	logic [31:0] p;
	logic [29:0] f, x;
	logic [61:0] prod_s1;
	quad_t       quad_s1;
	logic        swap_s1;
	logic [29:0] r_s2;
	logic [59:0] r2p_s2;
	quad_t       quad_dly_q [16];
	logic        swap_dly_q [16];

	logic [29:0] s_r [6];
	logic [29:0] s_r2 [6];
	logic [30:0] s_a [6];
	logic [29:0] c_r [6];
	logic [29:0] c_r2 [6];
	logic [30:0] c_a [6];
	logic signed [31:0] s0, c0;

	assign p = {phase_i, {(32-ANGLE_BITS){1'b0}}};
	assign f = p[29:0];
	// fold the upper half of the quadrant onto the lower octant
	assign x = f[29] ? 30'(Q30_ONE - {1'b0, f}) : f;

	always_ff @(posedge clk) begin
		prod_s1 <= 62'(x) * 62'(TWO_PI_Q29);
		quad_s1 <= quad_t'(p[31:30]);
		swap_s1 <= f[29];
		r_s2    <= prod_s1[60:31];
		r2p_s2  <= 60'(prod_s1[60:31]) * 60'(prod_s1[60:31]);
		quad_dly_q[0] <= quad_s1;
		swap_dly_q[0] <= swap_s1;
		for (int k = 1; k < 16; k++) begin
			quad_dly_q[k] <= quad_dly_q[k-1];
			swap_dly_q[k] <= swap_dly_q[k-1];
		end
	end

	assign s_r[0]  = r_s2;
	assign s_r2[0] = r2p_s2[59:30];
	assign s_a[0]  = Q30_ONE;
	assign c_r[0]  = r_s2;
	assign c_r2[0] = r2p_s2[59:30];
	assign c_a[0]  = Q30_ONE;

	for (genvar g = 0; g < 5; g++) begin : g_step
		usvg_horner_cell #(.K(sin_k(g)), .FINAL(g == 4)) u_sin (
			.clk  (clk),
			.r_i  (s_r[g]),
			.r2_i (s_r2[g]),
			.a_i  (s_a[g]),
			.r_o  (s_r[g+1]),
			.r2_o (s_r2[g+1]),
			.a_o  (s_a[g+1])
		);
		usvg_horner_cell #(.K(cos_k(g)), .FINAL(1'b0)) u_cos (
			.clk  (clk),
			.r_i  (c_r[g]),
			.r2_i (c_r2[g]),
			.a_i  (c_a[g]),
			.r_o  (c_r[g+1]),
			.r2_o (c_r2[g+1]),
			.a_o  (c_a[g+1])
		);
	end

	assign s0 = swap_dly_q[15] ? $signed({1'b0, c_a[5]}) : $signed({1'b0, s_a[5]});
	assign c0 = swap_dly_q[15] ? $signed({1'b0, s_a[5]}) : $signed({1'b0, c_a[5]});

	always_ff @(posedge clk) begin
		case (quad_dly_q[15])
			QUAD_0: begin
				sin_o <= s0;
				cos_o <= c0;
			end
			QUAD_1: begin
				sin_o <= c0;
				cos_o <= -s0;
			end
			QUAD_2: begin
				sin_o <= -s0;
				cos_o <= -c0;
			end
			default: begin
				sin_o <= -c0;
				cos_o <= s0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/uv_sphere_vertex_generator.sv -----
// top level of the uv sphere vertex generator
`default_nettype none
// usage:
// - an item (stack_index, sector_index) is taken on a rising edge with start high
//   and busy low; busy never rises, so one item can enter every clock
// - each item gives one vertex: position, normal, texture coordinates and an
//   index_error flag, shown for one cycle with done high
// - throughput is one vertex per clock
// - the latency is set by the bit-per-stage index dividers (one quotient bit
//   per cell) followed by the 15-stage horner sine/cosine cells
// - the receiver cannot stall; done beats must be taken when shown
// - registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data,
//   cfg_ready is always high; writes to index 7 are dropped
// - write registers only while no vertex is in flight
// - reset clears the in-flight valid line and loads the register defaults
//   (radius 1.0, center 0, 36 sectors, 18 stacks, outward normals)
module uv_sphere_vertex_generator #(
	parameter int ANGLE_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [usvg_pkg::IDX_W-1:0] stack_index,
	input  wire logic [usvg_pkg::IDX_W-1:0] sector_index,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [2:0]                 cfg_index,
	input  wire logic [31:0]                cfg_data,
	output logic                            done,
	output logic signed [31:0]              pos_x,
	output logic signed [31:0]              pos_y,
	output logic signed [31:0]              pos_z,
	output logic signed [15:0]              normal_x,
	output logic signed [15:0]              normal_y,
	output logic signed [15:0]              normal_z,
	output logic [16:0]                     tex_s,
	output logic [16:0]                     tex_t,
	output logic                            index_error
);
	import usvg_pkg::*;

	localparam int B   = quo_shift(ANGLE_BITS);
	localparam int QW  = IDX_W + B;
	localparam int LAT = pipe_latency(ANGLE_BITS);
	localparam logic [ANGLE_BITS-1:0] PH_QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

	// configuration registers
	logic [30:0]        radius_q;
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [IDX_W-1:0]   sectors_q, stacks_q;
	logic               inv_q;
	logic [IDX_W-1:0]   ns, nt;

	logic               accept;
	logic [LAT-1:0]     vld_q;

	// divider lanes, j over sectors and i over stacks
	logic [IDX_W-1:0] j_idx [QW+1];
	logic [IDX_W-1:0] j_rem [QW+1];
	logic [QW-1:0]    j_quo [QW+1];
	logic [IDX_W-1:0] i_idx [QW+1];
	logic [IDX_W-1:0] i_rem [QW+1];
	logic [QW-1:0]    i_quo [QW+1];

	logic [ANGLE_BITS:0]   vph_sum, pol_sum;
	logic [ANGLE_BITS-1:0] uph_s1, vph_s1;
	side_t                 side_dly_q [SC_LAT+5];
	side_t                 side_new;

	logic signed [31:0] su, cu, sv, cv;
	logic [61:0]        px_s2, py_s2;
	logic               xneg_s2, yneg_s2;
	logic signed [31:0] nz_s2;
	logic signed [31:0] nx_s3, ny_s3, nz_s3;
	logic [61:0]        prx_s4, pry_s4, prz_s4;
	logic               negx_s4, negy_s4, negz_s4;
	logic [15:0]        nrmx_s4, nrmy_s4, nrmz_s4;
	logic [31:0]        posx_s5, posy_s5, posz_s5;
	logic [15:0]        nrmx_s5, nrmy_s5, nrmz_s5;

	function automatic logic [30:0] mag31(input logic signed [31:0] d);
		return 31'(d[31] ? -d : d);
	endfunction

	// q30 product magnitude rounded half away from zero, sign applied
	function automatic logic signed [31:0] q30_round(input logic [61:0] pr, input logic neg);
		logic [61:0] s;
		s = pr + 62'd536870912;
		return neg ? -$signed({1'b0, s[60:30]}) : $signed({1'b0, s[60:30]});
	endfunction

	function automatic logic [15:0] normal_q15(input logic signed [31:0] d, input logic inv);
		logic [31:0] s;
		logic [16:0] m;
		s = {1'b0, mag31(d)} + 32'd16384;
		m = s[31:15];
		if (d[31] ^ inv) begin
			return 16'(-m);
		end
		return (m > 17'd32767) ? 16'h7fff : m[15:0];
	endfunction

	function automatic logic [31:0] place(input logic signed [31:0] c, input logic neg,
			input logic [61:0] pr);
		logic [61:0]        s;
		logic signed [33:0] m;
		logic signed [33:0] sum;
		s   = pr + 62'd536870912;
		m   = $signed({2'b00, s[61:30]});
		sum = neg ? 34'(c) - m : 34'(c) + m;
		if (sum > 34'sd2147483647) begin
			return 32'h7fff_ffff;
		end
		if (sum < -34'sd2147483648) begin
			return 32'h8000_0000;
		end
		return sum[31:0];
	endfunction

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign ns        = eff_count(sectors_q);
	assign nt        = eff_count(stacks_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= 31'd65536;
			cx_q      <= '0;
			cy_q      <= '0;
			cz_q      <= '0;
			sectors_q <= 11'd36;
			stacks_q  <= 11'd18;
			inv_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_RADIUS:   radius_q  <= cfg_data[30:0];
				REG_CENTER_X: cx_q      <= $signed(cfg_data);
				REG_CENTER_Y: cy_q      <= $signed(cfg_data);
				REG_CENTER_Z: cz_q      <= $signed(cfg_data);
				REG_SECTORS:  sectors_q <= cfg_data[IDX_W-1:0];
				REG_STACKS:   stacks_q  <= cfg_data[IDX_W-1:0];
				REG_INVERT:   inv_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// valid line, one bit per pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	assign j_idx[0] = sector_index;
	assign j_rem[0] = '0;
	assign j_quo[0] = '0;
	assign i_idx[0] = stack_index;
	assign i_rem[0] = '0;
	assign i_quo[0] = '0;

	// floor(index * 2^B / count), one quotient bit per cell
	for (genvar k = 0; k < QW; k++) begin : g_div
		usvg_div_cell #(.STEP(k), .QW(QW)) u_jcell (
			.clk    (clk),
			.d_i    (ns),
			.idx_i  (j_idx[k]),
			.rem_i  (j_rem[k]),
			.quot_i (j_quo[k]),
			.idx_o  (j_idx[k+1]),
			.rem_o  (j_rem[k+1]),
			.quot_o (j_quo[k+1])
		);
		usvg_div_cell #(.STEP(k), .QW(QW)) u_icell (
			.clk    (clk),
			.d_i    (nt),
			.idx_i  (i_idx[k]),
			.rem_i  (i_rem[k]),
			.quot_i (i_quo[k]),
			.idx_o  (i_idx[k+1]),
			.rem_o  (i_rem[k+1]),
			.quot_o (i_quo[k+1])
		);
	end

	// half-up rounding at the needed precision, wrapping mod one turn
	assign vph_sum = j_quo[QW][B-ANGLE_BITS-1 +: ANGLE_BITS+1] + {{ANGLE_BITS{1'b0}}, 1'b1};
	assign pol_sum = i_quo[QW][B-ANGLE_BITS +: ANGLE_BITS+1] + {{ANGLE_BITS{1'b0}}, 1'b1};

	// texture uses the quotient with 17 fraction bits
	assign side_new.tex_s = tex_round(j_quo[QW][B-17 +: TEX_W]);
	assign side_new.tex_t = tex_round(i_quo[QW][B-17 +: TEX_W]);
	assign side_new.err   = (i_idx[QW] > nt) || (j_idx[QW] > ns);

	always_ff @(posedge clk) begin
		vph_s1 <= vph_sum[ANGLE_BITS:1];
		uph_s1 <= PH_QUARTER - pol_sum[ANGLE_BITS:1];
		side_dly_q[0] <= side_new;
		for (int k = 1; k < SC_LAT + 5; k++) begin
			side_dly_q[k] <= side_dly_q[k-1];
		end
	end

	usvg_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_trig_u (
		.clk     (clk),
		.phase_i (uph_s1),
		.sin_o   (su),
		.cos_o   (cu)
	);

	usvg_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_trig_v (
		.clk     (clk),
		.phase_i (vph_s1),
		.sin_o   (sv),
		.cos_o   (cv)
	);

	always_ff @(posedge clk) begin
		// direction terms
		px_s2   <= 62'(mag31(cu)) * 62'(mag31(cv));
		py_s2   <= 62'(mag31(cu)) * 62'(mag31(sv));
		xneg_s2 <= cu[31] ^ cv[31];
		yneg_s2 <= cu[31] ^ sv[31];
		nz_s2   <= su;
		nx_s3   <= q30_round(px_s2, xneg_s2);
		ny_s3   <= q30_round(py_s2, yneg_s2);
		nz_s3   <= nz_s2;
		// radius scaling and normals
		prx_s4  <= 62'(radius_q) * 62'(mag31(nx_s3));
		pry_s4  <= 62'(radius_q) * 62'(mag31(ny_s3));
		prz_s4  <= 62'(radius_q) * 62'(mag31(nz_s3));
		negx_s4 <= nx_s3[31];
		negy_s4 <= ny_s3[31];
		negz_s4 <= nz_s3[31];
		nrmx_s4 <= normal_q15(nx_s3, inv_q);
		nrmy_s4 <= normal_q15(ny_s3, inv_q);
		nrmz_s4 <= normal_q15(nz_s3, inv_q);
		// center offset with saturation
		posx_s5 <= place(cx_q, negx_s4, prx_s4);
		posy_s5 <= place(cy_q, negy_s4, pry_s4);
		posz_s5 <= place(cz_q, negz_s4, prz_s4);
		nrmx_s5 <= nrmx_s4;
		nrmy_s5 <= nrmy_s4;
		nrmz_s5 <= nrmz_s4;
	end

	assign done        = vld_q[LAT-1];
	assign pos_x       = $signed(posx_s5);
	assign pos_y       = $signed(posy_s5);
	assign pos_z       = $signed(posz_s5);
	assign normal_x    = $signed(nrmx_s5);
	assign normal_y    = $signed(nrmy_s5);
	assign normal_z    = $signed(nrmz_s5);
	assign tex_s       = side_dly_q[SC_LAT+4].tex_s;
	assign tex_t       = side_dly_q[SC_LAT+4].tex_t;
	assign index_error = side_dly_q[SC_LAT+4].err;

endmodule
`default_nettype wire

// ----- sv/usvg_checker.sv -----
// port-level checks of the uv sphere vertex generator and their bind
`default_nettype none
module usvg_checker #(
	parameter int ANGLE_BITS = 16
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        cfg_ready,
	input wire logic        done,
	input wire logic [16:0] tex_s,
	input wire logic [16:0] tex_t
);
	import usvg_pkg::*;

	localparam int LAT = pipe_latency(ANGLE_BITS);

	logic [LAT-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			acc_q <= {acc_q[LAT-2:0], start && !busy};
		end
	end

	// every accepted beat comes out exactly once, a fixed time later
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == acc_q[LAT-1])
		else $error("result beat does not match accepted beat");

	a_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && cfg_ready)
		else $error("block refused a beat");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (tex_s <= 17'd65536) && (tex_t <= 17'd65536))
		else $error("texture coordinate above one");

endmodule

bind uv_sphere_vertex_generator usvg_checker #(.ANGLE_BITS(ANGLE_BITS)) u_usvg_checker (.*);
`default_nettype wire

// ----- bench/uv_sphere_vertex_generator_tb.sv -----
// self-checking testbench of the uv sphere vertex generator
`default_nettype none

module uv_sphere_vertex_generator_tb;
	import usvg_pkg::*;

	localparam int ANGLE_BITS = 16;
	localparam int LATENCY = 51;
	localparam int WATCHDOG = 4000;

	// one expected vertex
	typedef struct {
		logic signed [31:0] px, py, pz;
		logic signed [15:0] nx, ny, nz;
		logic [16:0] ts, tt;
		logic err;
	} vertex_t;

	// register copy used by the predictor
	logic [30:0] radius_q;
	logic signed [31:0] cen_x, cen_y, cen_z;
	logic [10:0] sectors_q, stacks_q;
	logic invert_q;

	int errors = 0;

	class vertex_board;
		vertex_t pending[$];

		function void note(vertex_t v);
			pending.insert(pending.size(), v);
		endfunction

		function void check(vertex_t got);
			vertex_t w;
			if (pending.size() == 0) begin
				$error("vertex with no expectation pending");
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.px !== w.px) begin $error("pos_x exp %0d got %0d", w.px, got.px); errors++; end
			if (got.py !== w.py) begin $error("pos_y exp %0d got %0d", w.py, got.py); errors++; end
			if (got.pz !== w.pz) begin $error("pos_z exp %0d got %0d", w.pz, got.pz); errors++; end
			if (got.nx !== w.nx) begin $error("normal_x exp %0d got %0d", w.nx, got.nx); errors++; end
			if (got.ny !== w.ny) begin $error("normal_y exp %0d got %0d", w.ny, got.ny); errors++; end
			if (got.nz !== w.nz) begin $error("normal_z exp %0d got %0d", w.nz, got.nz); errors++; end
			if (got.ts !== w.ts) begin $error("tex_s exp %0d got %0d", w.ts, got.ts); errors++; end
			if (got.tt !== w.tt) begin $error("tex_t exp %0d got %0d", w.tt, got.tt); errors++; end
			if (got.err !== w.err) begin
				$error("index_error exp %0d got %0d", w.err, got.err);
				errors++;
			end
		endfunction
	endclass

	vertex_board board = new();

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [10:0] stack_index = 0, sector_index = 0;
	logic cfg_valid = 0;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	logic busy, cfg_ready, done, index_error;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [16:0] tex_s, tex_t;

	int idle_pct = 0;
	int quiet = 0;

	always #6 clk = ~clk;

	uv_sphere_vertex_generator #(.ANGLE_BITS(ANGLE_BITS)) dut (.*);

	// sine and cosine of the first octant, Q30, x in Q0.32 turns
	function automatic void octant_trig(input longint unsigned x,
			output longint unsigned s, output longint unsigned c);
		longint unsigned r, r2, a;
		int sk[4] = '{72, 42, 20, 6};
		int ck[5] = '{90, 56, 30, 12, 2};
		r = (x * 64'd3373259426) >> 31;
		r2 = (r * r) >> 30;
		a = 64'd1 << 30;
		for (int k = 0; k < 4; k++) a = (64'd1 << 30) - ((r2 * a) >> 30) / sk[k];
		s = (r * a) >> 30;
		a = 64'd1 << 30;
		for (int k = 0; k < 5; k++) a = (64'd1 << 30) - ((r2 * a) >> 30) / ck[k];
		c = a;
	endfunction

	// full-turn sine and cosine from a phase with ANGLE_BITS fraction bits
	function automatic void turn_trig(input longint unsigned ph,
			output longint s, output longint c);
		longint unsigned p, f, s0, c0;
		quad_t q;
		p = (ph & ((64'd1 << ANGLE_BITS) - 1)) << (32 - ANGLE_BITS);
		q = quad_t'((p >> 30) & 3);
		f = p & ((64'd1 << 30) - 1);
		if (f < (64'd1 << 29)) octant_trig(f, s0, c0);
		else octant_trig((64'd1 << 30) - f, c0, s0);
		case (q)
			QUAD_0: begin s = s0; c = c0; end
			QUAD_1: begin s = c0; c = -longint'(c0 == c0 ? s0 : 0); end
			QUAD_2: begin s = -longint'(s0); c = -longint'(c0); end
			default: begin s = -longint'(c0); c = s0; end
		endcase
	endfunction

	function automatic longint unsigned mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint round_mul(longint a, longint b);
		longint unsigned m;
		m = (mag(a) * mag(b) + (64'd1 << 29)) >> 30;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [31:0] place(longint cen, longint d);
		longint unsigned m;
		longint v;
		m = (longint'(radius_q) * mag(d) + (64'd1 << 29)) >> 30;
		v = d < 0 ? cen - longint'(m) : cen + longint'(m);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic logic [15:0] to_q15(longint d0);
		longint d, v;
		d = invert_q ? -d0 : d0;
		v = (mag(d) + (64'd1 << 14)) >> 15;
		if (d < 0) v = -v;
		else if (v > 32767) v = 32767;
		return v[15:0];
	endfunction

	function automatic longint unsigned count_of(logic [10:0] n);
		if (n == 0) return 1;
		if (n > 1024) return 1024;
		return n;
	endfunction

	function automatic logic [16:0] tex_of(longint unsigned idx, longint unsigned n);
		longint unsigned v;
		v = ((idx << 17) + n) / (2 * n);
		return v > 65536 ? 17'd65536 : v[16:0];
	endfunction

	function automatic vertex_t predict_vertex(logic [10:0] i, logic [10:0] j);
		vertex_t v;
		longint unsigned ns, nt, vp, polar, up, msk;
		longint su, cu, sv, cv, dx, dy, dz;
		msk = (64'd1 << ANGLE_BITS) - 1;
		ns = count_of(sectors_q);
		nt = count_of(stacks_q);
		vp = (((longint'(j) << (ANGLE_BITS + 1)) + ns) / (2 * ns)) & msk;
		polar = (((longint'(i) << ANGLE_BITS) + nt) / (2 * nt)) & msk;
		up = ((64'd1 << (ANGLE_BITS - 2)) + (64'd1 << ANGLE_BITS) - polar) & msk;
		turn_trig(up, su, cu);
		turn_trig(vp, sv, cv);
		dx = round_mul(cu, cv);
		dy = round_mul(cu, sv);
		dz = su;
		v.px = place(cen_x, dx);
		v.py = place(cen_y, dy);
		v.pz = place(cen_z, dz);
		v.nx = to_q15(dx);
		v.ny = to_q15(dy);
		v.nz = to_q15(dz);
		v.ts = tex_of(j, ns);
		v.tt = tex_of(i, nt);
		v.err = (i > nt) || (j > ns);
		return v;
	endfunction

	// result side: every done beat is checked; watchdog counts quiet cycles
	always @(posedge clk) begin
		vertex_t got;
		if (done === 1'b1) begin
			got.px = pos_x; got.py = pos_y; got.pz = pos_z;
			got.nx = normal_x; got.ny = normal_y; got.nz = normal_z;
			got.ts = tex_s; got.tt = tex_t; got.err = index_error;
			board.check(got);
		end
		if ((done === 1'b1) || (start && !busy) || (cfg_valid && cfg_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// valid stays high for a following write; setting drops it
	task automatic write_reg(cfg_reg_t r, logic [31:0] d);
		cfg_valid <= 1;
		cfg_index <= r;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			REG_RADIUS: radius_q = d[30:0];
			REG_CENTER_X: cen_x = d;
			REG_CENTER_Y: cen_y = d;
			REG_CENTER_Z: cen_z = d;
			REG_SECTORS: sectors_q = d[10:0];
			REG_STACKS: stacks_q = d[10:0];
			default: invert_q = d[0];
		endcase
	endtask

	// wait for all pending vertices, then let the pipe drain
	task automatic drain();
		start <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// one vertex beat, with random gaps before it; start stays high for a
	// following beat and drain drops it
	task automatic send_vertex(logic [10:0] i, logic [10:0] j);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		stack_index <= i;
		sector_index <= j;
		do @(posedge clk); while (busy);
		board.note(predict_vertex(i, j));
	endtask

	// mostly in-range indices, a share beyond the counts or at the field limits
	task automatic random_burst(int n);
		logic [10:0] i, j;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0: begin i = 11'($urandom); j = 11'($urandom); end
				1: begin i = $urandom_range(1) ? 11'h7ff : 11'h000; j = 11'($urandom); end
				default: begin
					i = 11'($urandom_range(32'(count_of(stacks_q))));
					j = 11'($urandom_range(32'(count_of(sectors_q))));
				end
			endcase
			send_vertex(i, j);
		end
	endtask

	task automatic setting(logic [30:0] r, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [10:0] s, logic [10:0] t, logic inv);
		drain();
		write_reg(REG_RADIUS, {1'b0, r});
		write_reg(REG_CENTER_X, x);
		write_reg(REG_CENTER_Y, y);
		write_reg(REG_CENTER_Z, z);
		write_reg(REG_SECTORS, {21'b0, s});
		write_reg(REG_STACKS, {21'b0, t});
		write_reg(REG_INVERT, {31'b0, inv});
		cfg_valid <= 0;
	endtask

	initial begin
		radius_q = 31'd65536; cen_x = 0; cen_y = 0; cen_z = 0;
		sectors_q = 11'd36; stacks_q = 11'd18; invert_q = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: poles, equator, seam, out-of-range and field extremes at reset values
		send_vertex(0, 0);
		send_vertex(18, 36);
		send_vertex(9, 9);
		send_vertex(9, 18);
		send_vertex(19, 0);
		send_vertex(0, 37);
		send_vertex(11'h7ff, 11'h7ff);
		send_vertex(11'h400, 11'h555);
		send_vertex(11'h2aa, 11'h000);
		// zero counts act as one; huge radius and centers saturate
		setting(31'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fff0000, 0, 0, 1);
		send_vertex(0, 0);
		send_vertex(1, 1);
		send_vertex(2, 2);
		send_vertex(1, 0);
		// counts above the limit clamp
		setting(0, 32'h80000000, 32'h7fffffff, 32'h80000000, 11'h7ff, 11'h7ff, 0);
		send_vertex(1024, 1024);
		send_vertex(512, 256);
		send_vertex(1025, 3);
		// smallest legal counts
		setting(31'd65536, 0, 0, 0, 3, 2, 1);
		for (int i = 0; i <= 3; i++) send_vertex(i[10:0], i[10:0]);

		// random phases with three idling profiles
		for (int ph = 0; ph < 6; ph++) begin
			idle_pct = (ph % 3 == 0) ? 33 : (ph % 3 == 1) ? 51 : 0;
			setting(31'($urandom), $urandom, $urandom, $urandom,
				(ph == 2) ? 11'd1024 : 11'($urandom_range(3, 64)),
				(ph == 4) ? 11'd1024 : 11'($urandom_range(2, 64)), ph[0]);
			random_burst(120);
			drain();
			// pause until the pipe is empty, then go on
			random_burst(130);
		end
		idle_pct = 0;
		setting(31'd327680, 32'h00010000, 32'hffff0000, 0, 36, 18, 0);
		random_burst(40);

		drain();
		if (errors == 0 && board.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
sv/usvg_pkg.sv
sv/usvg_div_cell.sv
sv/usvg_horner_cell.sv
sv/usvg_sincos.sv
sv/uv_sphere_vertex_generator.sv
sv/usvg_checker.sv
bench/uv_sphere_vertex_generator_tb.sv
